FILE: rtl/core/epva_pkg.sv
`default_nettype none
package epva_pkg;

	localparam int DVD_W = 64;
	localparam int DEN_W = 38;
	localparam int CNT_W = 7;

	localparam logic [2:0] REG_RANGE_A     = 3'd0;
	localparam logic [2:0] REG_RANGE_B     = 3'd1;
	localparam logic [2:0] REG_VALUE_MODE  = 3'd2;
	localparam logic [2:0] REG_VEL_GAIN    = 3'd3;
	localparam logic [2:0] REG_SENS_GAIN   = 3'd4;

	localparam logic [1:0] MODE_ABS    = 2'd0;
	localparam logic [1:0] MODE_CENTER = 2'd1;
	localparam logic [1:0] MODE_REL7   = 2'd2;

	localparam logic       OP_ROTATE = 1'b0;
	localparam logic       OP_CLEAR  = 1'b1;

	localparam logic [31:0] DEN_SCALE  = 32'd230400000;
	// ceil(2^30 / 125): (us >> 3) * MS_RECIP >> 30 gives us / 1000
	localparam logic [31:0] MS_RECIP   = 32'd8589935;
	localparam logic [31:0] TURN_RESET = 32'd64;
	localparam logic [4:0]  M_MAX      = 5'd25;

	typedef enum logic [4:0] {
		ST_IDLE, ST_CLR, ST_MMS, ST_MSQ, ST_MVEL, ST_MM, ST_MSEN,
		ST_MSPAN, ST_MLO, ST_MHI, ST_ADDN, ST_MDEN, ST_DIVN, ST_WAITN,
		ST_SUM, ST_STEP, ST_COMMIT
	} state_t;

	typedef struct packed {
		logic             start;
		logic [CNT_W-1:0] count;
	} div_ctl_t;

	typedef struct packed {
		logic busy;
		logic ovf;
	} div_sts_t;

endpackage
`default_nettype wire

FILE: rtl/core/epva_div.sv
`default_nettype none
module epva_div import epva_pkg::*; #(
	parameter int QW = 55
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire div_ctl_t         ctl,
	input  wire logic [DVD_W-1:0] dividend,
	input  wire logic [DEN_W-1:0] den,
	output div_sts_t              sts,
	output logic      [QW-1:0]    quotient
);

	logic             busy_q;
	logic             ovf_q;
	logic [CNT_W-1:0] cnt_q;
	logic [DVD_W-1:0] dvd_q;
	logic [DEN_W-1:0] den_q;
	logic [DEN_W-1:0] rem_q;
	logic [QW-1:0]    quo_q;
	logic [DEN_W:0]   trial;
	logic             ge;

	// restoring division, one quotient bit per cycle
	assign trial = {rem_q, dvd_q[DVD_W-1]};
	assign ge    = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (ctl.start) begin
			busy_q <= 1'b1;
			cnt_q  <= ctl.count;
		end else if (busy_q) begin
			busy_q <= cnt_q != CNT_W'(1);
			cnt_q  <= cnt_q - CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			dvd_q <= dividend;
			den_q <= den;
			rem_q <= '0;
			quo_q <= '0;
			ovf_q <= 1'b0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[DVD_W-2:0], 1'b0};
			rem_q <= ge ? DEN_W'(trial - {1'b0, den_q}) : trial[DEN_W-1:0];
			quo_q <= {quo_q[QW-2:0], ge};
			// any quotient bit pushed past the kept width means saturation
			ovf_q <= ovf_q | quo_q[QW-1];
		end
	end

	assign sts.busy = busy_q;
	assign sts.ovf  = ovf_q;
	assign quotient = quo_q;

endmodule
`default_nettype wire

FILE: rtl/core/endless_pot_velocity_accumulator.sv
`default_nettype none
// channel  | direction | handshake            | payload
// input    | in        | in_valid / in_stall  | op, angle_delta, elapsed_us, stabilized
// result   | out       | out_valid / out_stall| value_out, turn_count, elapsed_msec, changed, trigger
// config   | in        | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// A rotation item holds the input closed until its result is written: one reciprocal
// multiply for the ms figure, further sequencer steps on the shared multiplier (squares,
// gains, span, numerator halves, denominator), and the bit-serial step divider.
// A clear goes from idle straight to writing its result, without the arithmetic.
// Reset is asynchronous; it restores the config and output registers and the turn count of 64.
// A result waiting under out_stall holds the final write of the next item.
module endless_pot_velocity_accumulator import epva_pkg::*; #(
	parameter int ELAPSED_LIMIT_MS = 500,
	parameter int FRAC_BITS        = 24
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic               op,
	input  wire logic signed [11:0] angle_delta,
	input  wire logic        [31:0] elapsed_us,
	input  wire logic               stabilized,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic signed      [15:0] value_out,
	output logic signed      [31:0] turn_count,
	output logic             [15:0] elapsed_msec,
	output logic                    changed,
	output logic                    trigger,
	input  wire logic               cfg_valid,
	output logic                    cfg_ready,
	input  wire logic        [2:0]  cfg_index,
	input  wire logic        [15:0] cfg_data
);

	localparam int LIM_W = $clog2(ELAPSED_LIMIT_MS * 1000 + 1);
	localparam logic [LIM_W-1:0] LIMIT_US = LIM_W'(ELAPSED_LIMIT_MS * 1000);
	localparam int QW = 31 + FRAC_BITS;
	localparam int TW = QW + 2;

	state_t state_q, state_d;

	logic signed [15:0] range_a_q, range_b_q;
	logic [1:0]         mode_q;
	logic [7:0]         vel_q, sen_q;

	logic signed [15:0] value_q;
	logic [31:0]        turn_q;
	logic [31:0]        frac_q;
	logic [15:0]        elapsed_q;
	logic               changed_q, trigger_q, out_valid_q;

	logic               stab_q, neg_q;
	logic [11:0]        ad_q;
	logic signed [15:0] lo_q, hi_q;
	logic [15:0]        span_q;
	logic [LIM_W-1:0]   elim_q;
	logic [15:0]        el_new_q;
	logic [4:0]         m_q;
	logic [22:0]        sq_q;
	logic [34:0]        t2_q;
	logic [9:0]         mm_q;
	logic [27:0]        t3_q, t4_q;
	logic [35:0]        inner_q;
	logic [63:0]        num_q;
	logic [31:0]        nhi_q;
	logic [DEN_W-1:0]   den_q;
	logic signed [TW-1:0] total_q;
	logic signed [31:0] step_q;
	logic [31:0]        frac_new_q;

	logic               slot_free, accept, commit;
	div_ctl_t           dctl;
	div_sts_t           dsts;
	logic [DVD_W-1:0]   div_dvd;
	logic [DEN_W-1:0]   div_den;
	logic [QW-1:0]      quo;

	logic [31:0]        mul_a, mul_b;
	logic [63:0]        mul_p;

	logic signed [12:0] d_eff;
	logic [11:0]        vel9;
	logic [17:0]        sen640;
	logic [QW-1:0]      qmag;
	logic signed [TW-1:0] smag;
	logic [TW-1:0]      tmag;
	logic [TW-FRAC_BITS-1:0] ip;
	logic [30:0]        ipsat;
	logic [FRAC_BITS-1:0] fp;
	logic signed [17:0] csum;
	logic signed [16:0] center;
	logic signed [32:0] nv_abs, nv_rel, nv_clamped_abs;
	logic signed [7:0]  rd;
	logic [6:0]         nv7;
	logic [15:0]        ms16;

	assign slot_free = !out_valid_q || !out_stall;
	assign accept    = in_valid && !in_stall;
	assign cfg_ready = 1'b1;

	epva_div #(.QW(QW)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (dctl),
		.dividend (div_dvd),
		.den      (div_den),
		.sts      (dsts),
		.quotient (quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		in_stall   = 1'b1;
		commit     = 1'b0;
		dctl.start = 1'b0;
		dctl.count = CNT_W'(DVD_W + FRAC_BITS);
		div_dvd    = num_q;
		div_den    = den_q;
		case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					state_d = (op == OP_CLEAR) ? ST_CLR : ST_MMS;
				end
			end
			ST_CLR: begin
				if (slot_free) begin
					commit  = 1'b1;
					state_d = ST_IDLE;
				end
			end
			ST_MMS:   state_d = ST_MSQ;
			ST_MSQ:   state_d = ST_MVEL;
			ST_MVEL:  state_d = ST_MM;
			ST_MM:    state_d = ST_MSEN;
			ST_MSEN:  state_d = ST_MSPAN;
			ST_MSPAN: state_d = ST_MLO;
			ST_MLO:   state_d = ST_MHI;
			ST_MHI:   state_d = ST_ADDN;
			ST_ADDN:  state_d = ST_MDEN;
			ST_MDEN:  state_d = ST_DIVN;
			ST_DIVN: begin
				dctl.start = 1'b1;
				state_d    = ST_WAITN;
			end
			ST_WAITN: if (!dsts.busy) state_d = ST_SUM;
			ST_SUM:   state_d = ST_STEP;
			ST_STEP:  state_d = ST_COMMIT;
			ST_COMMIT: begin
				if (slot_free) begin
					commit  = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// shared multiplier, operands chosen by the sequencer step
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			ST_MMS: begin
				mul_a = {{(35-LIM_W){1'b0}}, elim_q[LIM_W-1:3]};
				mul_b = MS_RECIP;
			end
			ST_MSQ: begin
				mul_a = {20'd0, ad_q};
				mul_b = {20'd0, ad_q};
			end
			ST_MVEL: begin
				mul_a = {9'd0, sq_q};
				mul_b = {20'd0, vel9};
			end
			ST_MM: begin
				mul_a = {27'd0, m_q};
				mul_b = {27'd0, m_q};
			end
			ST_MSEN: begin
				mul_a = {22'd0, mm_q};
				mul_b = {14'd0, sen640};
			end
			ST_MSPAN: begin
				mul_a = {20'd0, ad_q};
				mul_b = {16'd0, span_q};
			end
			ST_MLO: begin
				mul_a = {4'd0, t4_q};
				mul_b = inner_q[31:0];
			end
			ST_MHI: begin
				mul_a = {4'd0, t4_q};
				mul_b = {28'd0, inner_q[35:32]};
			end
			ST_MDEN: begin
				mul_a = {22'd0, mm_q};
				mul_b = DEN_SCALE;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end
	assign mul_p = mul_a * mul_b;

	assign d_eff  = (range_a_q > range_b_q) ? -13'(angle_delta) : 13'(angle_delta);
	assign vel9   = {1'b0, vel_q, 3'd0} + {4'd0, vel_q};
	assign sen640 = {1'b0, sen_q, 9'd0} + {3'd0, sen_q, 7'd0};
	assign ms16   = mul_p[45:30];

	assign qmag = {dsts.ovf ? 31'h7fff_ffff : quo[QW-1:FRAC_BITS], quo[FRAC_BITS-1:0]};
	assign smag = neg_q ? -$signed({2'b00, qmag}) : $signed({2'b00, qmag});

	assign tmag  = total_q[TW-1] ? TW'(-total_q) : TW'(total_q);
	assign ip    = tmag[TW-1:FRAC_BITS];
	assign ipsat = (|ip[TW-FRAC_BITS-1:31]) ? 31'h7fff_ffff : ip[30:0];
	assign fp    = tmag[FRAC_BITS-1:0];

	// centre: (range_b + 1 + range_a) / 2, truncated toward zero
	assign csum   = 18'(range_b_q) + 18'(range_a_q) + 18'sd1;
	assign center = 17'((csum + 18'(csum[17])) >>> 1);

	assign nv_abs = 33'(value_q) + 33'(step_q);
	assign nv_clamped_abs = (nv_abs < 33'(lo_q)) ? 33'(lo_q) :
	                        (nv_abs > 33'(hi_q)) ? 33'(hi_q) : nv_abs;

	always_comb begin
		if (value_q > 16'sd127) begin
			rd = -8'sd1;
		end else if (value_q < 16'sd0) begin
			rd = 8'sd0;
		end else if (value_q > 16'sd63) begin
			rd = 8'(value_q - 16'sd128);
		end else begin
			rd = 8'(value_q);
		end
	end
	assign nv_rel = 33'(rd) - 33'(step_q);
	assign nv7    = (nv_rel < -33'sd64) ? 7'h40 :
	                (nv_rel > 33'sd63)  ? 7'h3f : nv_rel[6:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			range_a_q <= 16'sd0;
			range_b_q <= 16'sd16383;
			mode_q    <= MODE_ABS;
			vel_q     <= 8'd50;
			sen_q     <= 8'd50;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_RANGE_A:    range_a_q <= cfg_data;
				REG_RANGE_B:    range_b_q <= cfg_data;
				REG_VALUE_MODE: mode_q    <= cfg_data[1:0];
				REG_VEL_GAIN:   vel_q     <= cfg_data[7:0];
				REG_SENS_GAIN:  sen_q     <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			value_q     <= '0;
			turn_q      <= TURN_RESET;
			frac_q      <= '0;
			elapsed_q   <= '0;
			changed_q   <= 1'b0;
			trigger_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (commit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (commit && state_q == ST_CLR) begin
				turn_q    <= TURN_RESET;
				changed_q <= 1'b0;
				trigger_q <= 1'b0;
				if (mode_q == MODE_CENTER) begin
					value_q <= center[15:0];
				end else if (mode_q == MODE_REL7) begin
					value_q <= '0;
				end
			end else if (commit) begin
				frac_q    <= frac_new_q;
				elapsed_q <= el_new_q;
				changed_q <= step_q != 32'sd0;
				trigger_q <= (step_q != 32'sd0) && stab_q;
				if (step_q != 32'sd0) begin
					turn_q <= turn_q + step_q;
					if (mode_q == MODE_ABS || mode_q == MODE_CENTER) begin
						value_q <= nv_clamped_abs[15:0];
					end else if (mode_q == MODE_REL7) begin
						value_q <= {9'd0, 7'(-nv7)};
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: if (accept) begin
				stab_q <= stabilized;
				neg_q  <= d_eff[12];
				ad_q   <= 12'(d_eff[12] ? -d_eff : d_eff);
				lo_q   <= (range_a_q < range_b_q) ? range_a_q : range_b_q;
				hi_q   <= (range_a_q < range_b_q) ? range_b_q : range_a_q;
				span_q <= (range_a_q < range_b_q) ? 16'(range_b_q - range_a_q)
				                                  : 16'(range_a_q - range_b_q);
				elim_q <= (elapsed_us > 32'(LIMIT_US)) ? LIMIT_US : elapsed_us[LIM_W-1:0];
			end
			ST_MMS: begin
				el_new_q <= ms16;
				m_q <= (ms16 == 16'd0) ? 5'd1 :
				       (ms16 > 16'(M_MAX)) ? M_MAX : ms16[4:0];
			end
			ST_MSQ:   sq_q <= mul_p[22:0];
			ST_MVEL:  t2_q <= mul_p[34:0];
			ST_MM:    mm_q <= mul_p[9:0];
			ST_MSEN:  t3_q <= mul_p[27:0];
			ST_MSPAN: begin
				t4_q    <= mul_p[27:0];
				inner_q <= {1'b0, t2_q} + {8'd0, t3_q};
			end
			ST_MLO:   num_q <= mul_p;
			ST_MHI:   nhi_q <= mul_p[31:0];
			ST_ADDN:  num_q <= num_q + {nhi_q, 32'd0};
			ST_MDEN:  den_q <= mul_p[DEN_W-1:0];
			ST_SUM:   total_q <= smag + TW'($signed(frac_q));
			ST_STEP: begin
				step_q     <= total_q[TW-1] ? -$signed({1'b0, ipsat}) : $signed({1'b0, ipsat});
				frac_new_q <= total_q[TW-1] ? -{{(32-FRAC_BITS){1'b0}}, fp}
				                            : {{(32-FRAC_BITS){1'b0}}, fp};
			end
			default: ;
		endcase
	end

	assign out_valid    = out_valid_q;
	assign value_out    = value_q;
	assign turn_count   = turn_q;
	assign elapsed_msec = elapsed_q;
	assign changed      = changed_q;
	assign trigger      = trigger_q;

endmodule
`default_nettype wire

FILE: rtl/core/epva_chk.sv
`default_nettype none
module epva_chk (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_valid,
	input wire logic        in_stall,
	input wire logic        out_valid,
	input wire logic        out_stall,
	input wire logic [15:0] value_out,
	input wire logic [31:0] turn_count,
	input wire logic        changed,
	input wire logic        trigger
);

	// one item at a time: a transfer in closes the input until it is done
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input accepted twice in a row");

	a_trigger_needs_change: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && trigger |-> changed)
		else $error("trigger without change");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(value_out) && $stable(turn_count))
		else $error("stalled result dropped or changed");

	// no step means the count is unchanged, unless a clear set it back
	a_no_step_count: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) && !changed |-> turn_count == $past(turn_count) ||
			turn_count == 32'd64)
		else $error("count moved without a step");

endmodule

bind endless_pot_velocity_accumulator epva_chk u_epva_chk (.*);
`default_nettype wire

FILE: test/tb.sv
`default_nettype none
module tb;
	import epva_pkg::*;

	localparam int LIMIT_MS   = 500;
	localparam int FRACW      = 24;
	localparam int SETTLE_CYC = 160;
	localparam int WATCHDOG   = 6000;

	typedef struct {
		logic signed [15:0] value;
		logic signed [31:0] turns;
		logic [15:0]        ms;
		logic               chg;
		logic               trig;
	} pot_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic op = OP_ROTATE;
	logic signed [11:0] angle_delta = '0;
	logic [31:0] elapsed_us = '0;
	logic stabilized = 1'b0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [15:0] value_out;
	logic signed [31:0] turn_count;
	logic [15:0] elapsed_msec;
	logic changed;
	logic trigger;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [2:0] cfg_index = '0;
	logic [15:0] cfg_data = '0;

	// predictor copy of the block
	logic signed [15:0] bound_a, bound_b;
	logic [1:0] mode;
	logic [7:0] vel_gain, sen_gain;
	logic [15:0] pot_value;
	logic [31:0] pot_turns, pot_frac;
	logic [15:0] pot_ms;

	pot_result_t pot_expected_q[$];
	int errors = 0;
	int items_sent = 0;
	int results_seen = 0;
	int idle_cycles = 0;
	bit quiet = 0;

	endless_pot_velocity_accumulator u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.op(op), .angle_delta(angle_delta), .elapsed_us(elapsed_us),
		.stabilized(stabilized),
		.out_valid(out_valid), .out_stall(out_stall),
		.value_out(value_out), .turn_count(turn_count), .elapsed_msec(elapsed_msec),
		.changed(changed), .trigger(trigger),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always #6 clk = ~clk;

	task automatic report(input string what, input longint got, input longint want);
		$display("mismatch %s: got %0d want %0d (result %0d)", what, got, want, results_seen);
		errors++;
	endtask

	task automatic predict_step(input logic o, input logic signed [11:0] dl,
			input logic [31:0] us, input logic stab);
		pot_result_t r;
		longint d, lo, hi, total, stp, frac, old, nv, rd, sq, sf, c;
		longint unsigned e, m, span, ad, inner, num, den, q, rem, fb, mag, ip, fp;
		bit neg, tneg;
		r.chg = 1'b0;
		r.trig = 1'b0;
		if (o == OP_CLEAR) begin
			pot_turns = TURN_RESET;
			if (mode == MODE_CENTER) begin
				c = (longint'(bound_b) + 1 + longint'(bound_a)) / 2;
				pot_value = c[15:0];
			end else if (mode == MODE_REL7) begin
				pot_value = '0;
			end
		end else begin
			e = 64'(us);
			if (e > 64'(LIMIT_MS * 1000)) e = 64'(LIMIT_MS * 1000);
			pot_ms = 16'(e / 1000);
			m = 64'(pot_ms);
			if (m < 1) m = 1;
			if (m > 25) m = 25;
			lo = (bound_a < bound_b) ? longint'(bound_a) : longint'(bound_b);
			hi = (bound_a < bound_b) ? longint'(bound_b) : longint'(bound_a);
			d = longint'(dl);
			if (bound_a > bound_b) d = -d;
			span = hi - lo;
			neg = d < 0;
			ad = neg ? -d : d;
			inner = 9 * ad * ad * longint'(vel_gain) + 640 * m * m * longint'(sen_gain);
			num = ad * span * inner;
			den = 64'd230400000 * m * m;
			q = num / den;
			rem = num % den;
			fb = 0;
			for (int i = 0; i < FRACW; i++) begin
				rem = rem << 1;
				fb = fb << 1;
				if (rem >= den) begin
					rem = rem - den;
					fb = fb | 1;
				end
			end
			if (q > 64'h7FFFFFFF) q = 64'h7FFFFFFF;
			sq = neg ? -longint'(q) : longint'(q);
			sf = neg ? -longint'(fb) : longint'(fb);
			total = sq * (64'sd1 <<< FRACW) + sf + longint'($signed(pot_frac));
			tneg = total < 0;
			mag = tneg ? -total : total;
			ip = mag >> FRACW;
			fp = mag & ((64'd1 << FRACW) - 1);
			if (ip > 64'h7FFFFFFF) ip = 64'h7FFFFFFF;
			stp = tneg ? -longint'(ip) : longint'(ip);
			frac = tneg ? -longint'(fp) : longint'(fp);
			pot_frac = frac[31:0];
			if (stp != 0) begin
				pot_turns = pot_turns + stp[31:0];
				old = longint'($signed(pot_value));
				if (mode == MODE_ABS || mode == MODE_CENTER) begin
					nv = old + stp;
					if (nv < lo) nv = lo;
					if (nv > hi) nv = hi;
					pot_value = nv[15:0];
				end else if (mode == MODE_REL7) begin
					if (old > 127) rd = -1;
					else if (old < 0) rd = 0;
					else if (old > 63) rd = old - 128;
					else rd = old;
					nv = rd - stp;
					if (nv < -64) nv = -64;
					if (nv > 63) nv = 63;
					nv = -nv;
					pot_value = {9'd0, nv[6:0]};
				end
				r.chg = 1'b1;
				r.trig = stab;
			end
		end
		r.value = pot_value;
		r.turns = pot_turns;
		r.ms = pot_ms;
		pot_expected_q.push_back(r);
	endtask

	task automatic send_item(input logic o, input logic signed [11:0] dl,
			input logic [31:0] us, input logic stab);
		if (!quiet && $urandom_range(0, 3) == 0) begin
			@(negedge clk);
			in_valid = 1'b0;
			repeat ($urandom_range(1, 7) - 1) @(negedge clk);
		end
		@(negedge clk);
		op = o;
		angle_delta = dl;
		elapsed_us = us;
		stabilized = stab;
		in_valid = 1'b1;
		do @(posedge clk); while (in_stall);
		predict_step(o, dl, us, stab);
		items_sent++;
	endtask

	// drop valid while the block is still busy so the last item is not sent again
	task automatic drain();
		@(negedge clk);
		in_valid = 1'b0;
		while (pot_expected_q.size() != 0) @(posedge clk);
		repeat (SETTLE_CYC) @(posedge clk);
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [15:0] data);
		drain();
		@(negedge clk);
		cfg_index = idx;
		cfg_data = data;
		cfg_valid = 1'b1;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_RANGE_A:    bound_a = data;
			REG_RANGE_B:    bound_b = data;
			REG_VALUE_MODE: mode = data[1:0];
			REG_VEL_GAIN:   vel_gain = data[7:0];
			REG_SENS_GAIN:  sen_gain = data[7:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	task automatic setup(input logic [15:0] a, input logic [15:0] b, input logic [1:0] md,
			input logic [7:0] vg, input logic [7:0] sg);
		write_reg(REG_RANGE_A, a);
		write_reg(REG_RANGE_B, b);
		write_reg(REG_VALUE_MODE, {14'd0, md});
		write_reg(REG_VEL_GAIN, {8'd0, vg});
		write_reg(REG_SENS_GAIN, {8'd0, sg});
	endtask

	task automatic send_random();
		logic signed [11:0] dl;
		logic [31:0] us;
		int k;
		k = $urandom_range(0, 9);
		if (k < 5) dl = 12'($signed($urandom_range(0, 60)) - 30);
		else if (k < 8) dl = 12'($signed($urandom_range(0, 3600)) - 1800);
		else dl = ($urandom_range(0, 1) != 0) ? 12'sd1800 : -12'sd1800;
		k = $urandom_range(0, 9);
		if (k < 7) us = $urandom_range(0, 30000);
		else if (k < 9) us = $urandom_range(0, 600000);
		else us = $urandom();
		send_item(($urandom_range(0, 19) == 0) ? OP_CLEAR : OP_ROTATE, dl, us,
			1'($urandom_range(0, 1)));
	endtask

	// result stall in random bursts
	initial begin
		int burst;
		burst = 0;
		forever begin
			@(negedge clk);
			if (quiet) begin
				out_stall = 1'b0;
			end else if (burst > 0) begin
				burst--;
			end else if ($urandom_range(0, 4) == 0) begin
				out_stall = 1'b1;
				burst = $urandom_range(1, 7) - 1;
			end else begin
				out_stall = 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (pot_expected_q.size() == 0) begin
				$display("unexpected result value %0d", value_out);
				errors++;
			end else begin
				pot_result_t w;
				w = pot_expected_q.pop_front();
				if (value_out !== w.value) report("value_out", value_out, w.value);
				if (turn_count !== w.turns) report("turn_count", turn_count, w.turns);
				if (elapsed_msec !== w.ms) report("elapsed_msec", elapsed_msec, w.ms);
				if (changed !== w.chg) report("changed", changed, w.chg);
				if (trigger !== w.trig) report("trigger", trigger, w.trig);
			end
			results_seen++;
		end
	end

	// watchdog on cycles with no transfer on any channel
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > WATCHDOG) begin
			$display("tb NOT OK");
			$finish;
		end
	end

	task automatic test_defaults();
		send_item(OP_ROTATE, 12'sd0, 32'd0, 1'b1);
		send_item(OP_ROTATE, 12'sd1800, 32'd0, 1'b1);
		send_item(OP_ROTATE, -12'sd1800, 32'hFFFFFFFF, 1'b0);
		send_item(OP_ROTATE, 12'sd5, 32'd25000, 1'b1);
		send_item(OP_ROTATE, -12'sd1, 32'd499999, 1'b1);
		send_item(OP_CLEAR, 12'sd7, 32'd1234, 1'b1);
	endtask

	task automatic test_huge_step();
		setup(16'h8000, 16'h7FFF, MODE_ABS, 8'd255, 8'd255);
		send_item(OP_ROTATE, 12'sd1800, 32'd0, 1'b1);
		send_item(OP_ROTATE, -12'sd1800, 32'd999, 1'b1);
		send_item(OP_ROTATE, -12'sd1800, 32'd1000, 1'b0);
		// zero gains and zero span give a zero step
		setup(16'd100, 16'd100, MODE_ABS, 8'd0, 8'd0);
		send_item(OP_ROTATE, 12'sd1800, 32'd3000, 1'b1);
	endtask

	task automatic test_modes();
		// reversed bounds invert the delta
		setup(16'd500, -16'sd500, MODE_ABS, 8'd80, 8'd200);
		send_item(OP_ROTATE, 12'sd900, 32'd2000, 1'b1);
		send_item(OP_ROTATE, 12'sd900, 32'd2000, 1'b1);
		write_reg(REG_VALUE_MODE, {14'd0, MODE_REL7});
		send_item(OP_ROTATE, 12'sd10, 32'd20000, 1'b1);
		setup(16'd0, 16'd16383, MODE_ABS, 8'd50, 8'd50);
		send_item(OP_ROTATE, 12'sd1800, 32'd1000, 1'b1);
		write_reg(REG_VALUE_MODE, {14'd0, MODE_REL7});
		send_item(OP_ROTATE, 12'sd40, 32'd5000, 1'b1);
		send_item(OP_ROTATE, -12'sd300, 32'd1000, 1'b1);
		send_item(OP_CLEAR, 12'sd0, 32'd0, 1'b0);
		write_reg(REG_VALUE_MODE, {14'd0, MODE_CENTER});
		send_item(OP_CLEAR, 12'sd0, 32'd0, 1'b0);
		send_item(OP_ROTATE, 12'sd700, 32'd8000, 1'b1);
		// unused mode: value holds, count and flags still move
		write_reg(REG_VALUE_MODE, {14'd0, 2'd3});
		send_item(OP_ROTATE, -12'sd700, 32'd8000, 1'b1);
		send_item(OP_CLEAR, 12'sd0, 32'd0, 1'b0);
	endtask

	task automatic test_random(input int phases, input int per_phase);
		logic [15:0] a, b;
		for (int p = 0; p < phases; p++) begin
			case ($urandom_range(0, 3))
				0: begin a = 16'h8000; b = 16'h7FFF; end
				1: begin a = 16'h7FFF; b = 16'h8000; end
				2: begin
					a = 16'($urandom_range(0, 400) - 200);
					b = 16'(a + $urandom_range(0, 300));
				end
				default: begin a = 16'($urandom()); b = 16'($urandom()); end
			endcase
			setup(a, b, 2'($urandom_range(0, 3)), 8'($urandom()), 8'($urandom()));
			for (int i = 0; i < per_phase; i++) send_random();
			if (p == 1) drain();
		end
	endtask

	initial begin
		bound_a = 16'sd0;
		bound_b = 16'sd16383;
		mode = MODE_ABS;
		vel_gain = 8'd50;
		sen_gain = 8'd50;
		pot_value = '0;
		pot_turns = TURN_RESET;
		pot_frac = '0;
		pot_ms = '0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		test_defaults();
		test_huge_step();
		test_modes();
		test_random(6, 100);
		quiet = 1'b1;
		test_random(1, 80);
		drain();
		$display("sent %0d items, checked %0d results", items_sent, results_seen);
		$display("covered clamp and relative modes, reversed and extreme bounds, clears, stalls");
		if (errors == 0 && pot_expected_q.size() == 0) begin
			$display("tb OK");
		end else begin
			$display("tb NOT OK");
		end
		$finish;
	end
endmodule
`default_nettype wire

FILE: filelist.f
rtl/core/epva_pkg.sv
rtl/core/epva_div.sv
rtl/core/endless_pot_velocity_accumulator.sv
rtl/core/epva_chk.sv
test/tb.sv
